// ===== rtl/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int unsigned ADDRESS_BITS_DEF = 16;
  localparam int unsigned KEY_BITS         = 64;
  localparam int unsigned JOY_BITS         = 6;
  localparam int unsigned CFG_INDEX_BITS   = 1;
  localparam int unsigned CFG_DATA_BITS    = 2;
  localparam int unsigned FIFO_DEPTH       = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HAS_BASIC_ROM = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CART_TYPE     = 1'd1;

  localparam logic [1:0] CART_TYPE_NONE = 2'd0;
  localparam logic [1:0] CART_TYPE_32K  = 2'd3;

  // bus addresses
  localparam logic [15:0] ADDR_LOW_BANK   = 16'h4000;
  localparam logic [15:0] ADDR_HIGH_BANK  = 16'h8000;
  localparam logic [15:0] ADDR_ROM_END    = 16'hC000;
  localparam logic [15:0] ADDR_IO_BASE    = 16'hE000;
  localparam logic [15:0] ADDR_VDP_DATA   = 16'hE000;
  localparam logic [15:0] ADDR_VDP_CTRL   = 16'hE002;
  localparam logic [15:0] ADDR_CART_OFF   = 16'hE108;
  localparam logic [15:0] ADDR_CART_ON    = 16'hE10C;
  localparam logic [15:0] ADDR_ZERO_A     = 16'hE110;
  localparam logic [15:0] ADDR_PSG        = 16'hE200;
  localparam logic [15:0] ADDR_JOY_ONE    = 16'hE800;
  localparam logic [15:0] ADDR_ZERO_B     = 16'hE820;
  localparam logic [15:0] ADDR_KEYS_A     = 16'hEA00;
  localparam logic [15:0] ADDR_KEYS_B     = 16'hEC00;
  localparam logic [15:0] ADDR_CASS_JOY   = 16'hEE00;
  localparam logic [7:0]  CASS_PAGE       = 8'hEE;

  localparam logic [1:0]  CASS_SUB_OUT    = 2'd0;
  localparam logic [1:0]  CASS_SUB_REMOTE = 2'd1;

  // cru addresses, low 12 bits
  localparam logic [8:0]  CRU_KEY_BASE    = 9'h1D8;  // 0xEC0 >> 3
  localparam logic [11:0] CRU_CASS_IN     = 12'hED0;

  typedef enum logic [1:0] {
    OP_MEM_READ  = 2'd0,
    OP_MEM_WRITE = 2'd1,
    OP_CRU_READ  = 2'd2,
    OP_CASS_IN   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_ROM_FETCH = 3'd1,
    KIND_VDP_READ  = 3'd2,
    KIND_VDP_WRITE = 3'd3,
    KIND_PSG_WRITE = 3'd4,
    KIND_CASS_OUT  = 3'd5,
    KIND_REMOTE    = 3'd6,
    KIND_INT4      = 3'd7
  } kind_e;

  localparam logic [1:0] ROM_IPL   = 2'd0;
  localparam logic [1:0] ROM_BASIC = 2'd1;
  localparam logic [1:0] ROM_CART  = 2'd2;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [1:0]  rom_sel;
    logic [14:0] rom_off;
    logic        vdp_port;
    logic        level;
    logic        last;
  } res_t;

  // unconnected matrix positions read as zero
  localparam logic [7:0] ROW_MASK [8] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFC, 8'hDE, 8'h0F
  };

  function automatic logic [7:0] key_row(logic [KEY_BITS-1:0] keys, logic [2:0] row);
    return keys[8*row +: 8] & ROW_MASK[row];
  endfunction

  // joystick to bits 2..7: b1, b2, down, left, up, right
  function automatic logic [7:0] joy_byte(logic [JOY_BITS-1:0] j);
    return {j[3], j[0], j[2], j[1], j[5], j[4], 2'b00};
  endfunction

endpackage

// ===== rtl/home_computer_bus_decoder.sv =====
`timescale 1ns / 1ps
// results are registered into the result fifo before they reach the output
// throughput: one item per cycle while in_ready_o stays high and items give at most one result each;
//   an item with two results (remote off) takes two output beats
// in_ready_o follows the fill of a four-entry result fifo that needs two free slots
// reset: rst_ni low clears config, cart mapping, cassette state and the fifo at once
module home_computer_bus_decoder #(
  parameter int unsigned ADDRESS_BITS = hcbd_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hcbd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [hcbd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // bus event channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          operation_i,
  input  logic [ADDRESS_BITS-1:0]             address_i,
  input  logic [7:0]                          write_data_i,
  input  logic                                cassette_level_i,
  input  logic [hcbd_pkg::KEY_BITS-1:0]       key_rows_i,
  input  logic [hcbd_pkg::JOY_BITS-1:0]       joy_one_i,
  input  logic [hcbd_pkg::JOY_BITS-1:0]       joy_two_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          result_kind_o,
  output logic [7:0]                          read_value_o,
  output logic [1:0]                          rom_select_o,
  output logic [14:0]                         rom_offset_o,
  output logic                                vdp_port_o,
  output logic                                signal_level_o,
  output logic                                last_result_o
);

  localparam int unsigned PTR_BITS = $clog2(hcbd_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(hcbd_pkg::FIFO_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FILL_LIMIT = CNT_BITS'(hcbd_pkg::FIFO_DEPTH - 2);

  // configuration and bus state
  logic       has_basic_q;
  logic [1:0] cart_type_q;
  logic       cart_mapped_q, cart_mapped_d;
  logic       cass_sig_q, cass_sig_d;
  logic       cass_rem_q, cass_rem_d;

  // result fifo
  hcbd_pkg::res_t        fifo_q [hcbd_pkg::FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]   count_q;

  logic                  in_fire, out_fire, cfg_fire;
  hcbd_pkg::res_t        res0, res1;
  logic [1:0]            n_res;

  logic [15:0]           addr;
  logic [11:0]           cru;
  logic [7:0]            r0, r6, r7, v;
  logic                  rm;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign in_ready_o  = (count_q <= FILL_LIMIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  assign addr = 16'(address_i);
  assign cru  = addr[11:0];
  assign r0   = hcbd_pkg::key_row(key_rows_i, 3'd0);
  assign r6   = hcbd_pkg::key_row(key_rows_i, 3'd6);
  assign r7   = hcbd_pkg::key_row(key_rows_i, 3'd7);
  assign rm   = (write_data_i == 8'h00);

  // decode one bus event into up to two results and the next state
  always_comb begin
    res0          = '0;
    res1          = '0;
    n_res         = 2'd0;
    v             = 8'hFF;
    cart_mapped_d = cart_mapped_q;
    cass_sig_d    = cass_sig_q;
    cass_rem_d    = cass_rem_q;
    unique case (hcbd_pkg::op_e'(operation_i))
      hcbd_pkg::OP_MEM_READ: begin
        n_res = 2'd1;
        if (addr < hcbd_pkg::ADDR_ROM_END) begin
          res0.kind = hcbd_pkg::KIND_ROM_FETCH;
          if (cart_mapped_q && cart_type_q == hcbd_pkg::CART_TYPE_32K &&
              addr >= hcbd_pkg::ADDR_LOW_BANK) begin
            // 32k cartridge covers 0x4000-0xbfff
            res0.rom_sel = hcbd_pkg::ROM_CART;
            res0.rom_off = 15'(addr - hcbd_pkg::ADDR_LOW_BANK);
          end else if (addr < hcbd_pkg::ADDR_HIGH_BANK) begin
            res0.rom_sel = hcbd_pkg::ROM_IPL;
            res0.rom_off = addr[14:0];
          end else begin
            res0.rom_sel = cart_mapped_q ? hcbd_pkg::ROM_CART : hcbd_pkg::ROM_BASIC;
            res0.rom_off = addr[14:0];
          end
        end else if (addr < hcbd_pkg::ADDR_IO_BASE) begin
          res0.kind  = hcbd_pkg::KIND_DATA;
          res0.value = 8'hFF;
        end else if (addr == hcbd_pkg::ADDR_VDP_DATA || addr == hcbd_pkg::ADDR_VDP_CTRL) begin
          res0.kind     = hcbd_pkg::KIND_VDP_READ;
          res0.vdp_port = (addr == hcbd_pkg::ADDR_VDP_CTRL);
        end else begin
          if (addr == hcbd_pkg::ADDR_ZERO_A || addr == hcbd_pkg::ADDR_ZERO_B) begin
            v = 8'h00;
          end else if (addr == hcbd_pkg::ADDR_JOY_ONE) begin
            v = hcbd_pkg::joy_byte(joy_one_i);
          end else if (addr == hcbd_pkg::ADDR_KEYS_A) begin
            v = {r0[1], r0[0], r6[3], r6[6], r6[7], r6[4], 2'b00};
          end else if (addr == hcbd_pkg::ADDR_KEYS_B) begin
            v = {r7[3:0], r0[7], r0[6], 2'b00};
          end else if (addr == hcbd_pkg::ADDR_CASS_JOY) begin
            v = hcbd_pkg::joy_byte(joy_two_i);
          end
          res0.kind  = hcbd_pkg::KIND_DATA;
          res0.value = v;
        end
      end
      hcbd_pkg::OP_MEM_WRITE: begin
        if (addr < hcbd_pkg::ADDR_IO_BASE) begin
          n_res = 2'd0;
        end else if (addr == hcbd_pkg::ADDR_VDP_DATA || addr == hcbd_pkg::ADDR_VDP_CTRL) begin
          n_res         = 2'd1;
          res0.kind     = hcbd_pkg::KIND_VDP_WRITE;
          res0.value    = write_data_i;
          res0.vdp_port = (addr == hcbd_pkg::ADDR_VDP_CTRL);
        end else if (addr == hcbd_pkg::ADDR_CART_OFF && has_basic_q) begin
          cart_mapped_d = 1'b0;
        end else if (addr == hcbd_pkg::ADDR_CART_ON && has_basic_q) begin
          cart_mapped_d = 1'b1;
        end else if (addr == hcbd_pkg::ADDR_PSG) begin
          n_res      = 2'd1;
          res0.kind  = hcbd_pkg::KIND_PSG_WRITE;
          res0.value = write_data_i;
        end else if (addr[15:8] == hcbd_pkg::CASS_PAGE && addr[4:0] == 5'd0) begin
          if (addr[7:6] == hcbd_pkg::CASS_SUB_OUT) begin
            if (addr[5] != cass_sig_q) begin
              n_res      = 2'd1;
              res0.kind  = hcbd_pkg::KIND_CASS_OUT;
              res0.level = addr[5];
              cass_sig_d = addr[5];
            end
          end else if (addr[7:6] == hcbd_pkg::CASS_SUB_REMOTE) begin
            if (rm != cass_rem_q) begin
              cass_rem_d = rm;
              if (!rm) begin
                // remote off drops int4 before the remote beat
                n_res      = 2'd2;
                res0.kind  = hcbd_pkg::KIND_INT4;
                res1.kind  = hcbd_pkg::KIND_REMOTE;
                res1.level = 1'b0;
              end else begin
                n_res      = 2'd1;
                res0.kind  = hcbd_pkg::KIND_REMOTE;
                res0.level = 1'b1;
              end
            end
          end
        end
      end
      hcbd_pkg::OP_CRU_READ: begin
        n_res = 2'd1;
        if (cru[11:3] == hcbd_pkg::CRU_KEY_BASE) begin
          v = hcbd_pkg::key_row(key_rows_i, cru[2:0]);
          if (cru[2:0] == 3'd4) begin
            v = v | hcbd_pkg::joy_byte(joy_one_i);
          end else if (cru[2:0] == 3'd5) begin
            v = v | hcbd_pkg::joy_byte(joy_two_i);
          end
        end else if (cru == hcbd_pkg::CRU_CASS_IN) begin
          v = {7'd0, cass_sig_q};
        end
        res0.kind  = hcbd_pkg::KIND_DATA;
        res0.value = v;
      end
      hcbd_pkg::OP_CASS_IN: begin
        if (cassette_level_i != cass_sig_q) begin
          cass_sig_d = cassette_level_i;
          if (cass_rem_q) begin
            n_res      = 2'd1;
            res0.kind  = hcbd_pkg::KIND_INT4;
            res0.level = cassette_level_i;
          end
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  // control state; config writes must come only while idle, the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_basic_q   <= 1'b0;
      cart_type_q   <= hcbd_pkg::CART_TYPE_NONE;
      cart_mapped_q <= 1'b0;
      cass_sig_q    <= 1'b0;
      cass_rem_q    <= 1'b0;
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      count_q       <= '0;
    end else begin
      if (cfg_fire) begin
        if (cfg_index_i == hcbd_pkg::CFG_HAS_BASIC_ROM) begin
          has_basic_q <= cfg_data_i[0];
        end else begin
          cart_type_q   <= cfg_data_i;
          cart_mapped_q <= (cfg_data_i != hcbd_pkg::CART_TYPE_NONE);
        end
      end else if (in_fire) begin
        cart_mapped_q <= cart_mapped_d;
      end
      if (in_fire) begin
        cass_sig_q <= cass_sig_d;
        cass_rem_q <= cass_rem_d;
        wr_ptr_q   <= wr_ptr_q + PTR_BITS'(n_res);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (in_fire ? CNT_BITS'(n_res) : '0) - CNT_BITS'(out_fire);
    end
  end

  // result storage, payload only
  always_ff @(posedge clk_i) begin
    if (in_fire && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= res1;
    end
  end

  assign result_kind_o  = fifo_q[rd_ptr_q].kind;
  assign read_value_o   = fifo_q[rd_ptr_q].value;
  assign rom_select_o   = fifo_q[rd_ptr_q].rom_sel;
  assign rom_offset_o   = fifo_q[rd_ptr_q].rom_off;
  assign vdp_port_o     = fifo_q[rd_ptr_q].vdp_port;
  assign signal_level_o = fifo_q[rd_ptr_q].level;
  assign last_result_o  = fifo_q[rd_ptr_q].last;

endmodule

// ===== tb/sv/bus_decode_checker.sv =====
`timescale 1ns / 1ps

module bus_decode_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [hcbd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [hcbd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [1:0]                          operation_i,
  input  logic [15:0]                         address_i,
  input  logic [7:0]                          write_data_i,
  input  logic                                cassette_level_i,
  input  logic [hcbd_pkg::KEY_BITS-1:0]       key_rows_i,
  input  logic [hcbd_pkg::JOY_BITS-1:0]       joy_one_i,
  input  logic [hcbd_pkg::JOY_BITS-1:0]       joy_two_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [2:0]                          result_kind_i,
  input  logic [7:0]                          read_value_i,
  input  logic [1:0]                          rom_select_i,
  input  logic [14:0]                         rom_offset_i,
  input  logic                                vdp_port_i,
  input  logic                                signal_level_i,
  input  logic                                last_result_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o,
  output int unsigned                         results_seen_o
);

  localparam logic [7:0]  OPEN_BUS    = 8'hFF;
  // rows 7..0, unconnected switches cleared
  localparam logic [63:0] MATRIX_MASK = 64'h0FDE_FCFF_FFFF_FFFF;

  hcbd_pkg::res_t decoded_results [$];
  logic        basic_present;
  logic [1:0]  cart_size;
  logic        cart_on;
  logic        cass_level;
  logic        remote_on;
  int unsigned fails = 0;
  int unsigned seen  = 0;

  assign fail_count_o   = fails;
  assign results_seen_o = seen;
  assign pending_o      = decoded_results.size();

  function automatic logic [7:0] matrix_row(logic [63:0] keys, logic [2:0] row);
    logic [63:0] live;
    live = keys & MATRIX_MASK;
    return live[8*row +: 8];
  endfunction

  // stick bits land on 2..7 as b1, b2, down, left, up, right
  function automatic logic [7:0] stick_bits(logic [5:0] j);
    logic [7:0] b;
    b    = 8'h00;
    b[2] = j[4];
    b[3] = j[5];
    b[4] = j[1];
    b[5] = j[2];
    b[6] = j[0];
    b[7] = j[3];
    return b;
  endfunction

  function automatic hcbd_pkg::res_t make_beat(hcbd_pkg::kind_e k, logic [7:0] v,
                                               logic [1:0] sel, logic [14:0] off,
                                               logic port, logic lvl);
    hcbd_pkg::res_t b;
    b.kind     = k;
    b.value    = v;
    b.rom_sel  = sel;
    b.rom_off  = off;
    b.vdp_port = port;
    b.level    = lvl;
    b.last     = 1'b0;
    return b;
  endfunction

  task automatic decode_bus_event(hcbd_pkg::op_e op, logic [15:0] addr, logic [7:0] data,
                                  logic lvl, logic [63:0] keys, logic [5:0] j1,
                                  logic [5:0] j2);
    hcbd_pkg::res_t beats [$];
    logic [7:0]  v;
    logic [7:0]  r0;
    logic [7:0]  r6;
    logic [7:0]  r7;
    logic [11:0] cru;
    logic        want_remote;
    r0  = matrix_row(keys, 3'd0);
    r6  = matrix_row(keys, 3'd6);
    r7  = matrix_row(keys, 3'd7);
    cru = addr[11:0];
    case (op)
      hcbd_pkg::OP_MEM_READ: begin
        if (addr < hcbd_pkg::ADDR_ROM_END) begin
          if (cart_on && cart_size == hcbd_pkg::CART_TYPE_32K &&
              addr >= hcbd_pkg::ADDR_LOW_BANK) begin
            beats.push_back(make_beat(hcbd_pkg::KIND_ROM_FETCH, 8'h00, hcbd_pkg::ROM_CART,
                                      15'(addr - hcbd_pkg::ADDR_LOW_BANK), 1'b0, 1'b0));
          end else if (addr < hcbd_pkg::ADDR_HIGH_BANK) begin
            beats.push_back(make_beat(hcbd_pkg::KIND_ROM_FETCH, 8'h00, hcbd_pkg::ROM_IPL,
                                      addr[14:0], 1'b0, 1'b0));
          end else begin
            beats.push_back(make_beat(hcbd_pkg::KIND_ROM_FETCH, 8'h00,
                                      cart_on ? hcbd_pkg::ROM_CART : hcbd_pkg::ROM_BASIC,
                                      15'(addr - hcbd_pkg::ADDR_HIGH_BANK), 1'b0, 1'b0));
          end
        end else if (addr < hcbd_pkg::ADDR_IO_BASE) begin
          beats.push_back(make_beat(hcbd_pkg::KIND_DATA, OPEN_BUS, hcbd_pkg::ROM_IPL, 15'd0,
                                    1'b0, 1'b0));
        end else if (addr == hcbd_pkg::ADDR_VDP_DATA || addr == hcbd_pkg::ADDR_VDP_CTRL) begin
          beats.push_back(make_beat(hcbd_pkg::KIND_VDP_READ, 8'h00, hcbd_pkg::ROM_IPL, 15'd0,
                                    addr == hcbd_pkg::ADDR_VDP_CTRL, 1'b0));
        end else begin
          if (addr == hcbd_pkg::ADDR_ZERO_A || addr == hcbd_pkg::ADDR_ZERO_B) begin
            v = 8'h00;
          end else if (addr == hcbd_pkg::ADDR_JOY_ONE) begin
            v = stick_bits(j1);
          end else if (addr == hcbd_pkg::ADDR_KEYS_A) begin
            v = {r0[1], r0[0], r6[3], r6[6], r6[7], r6[4], 2'b00};
          end else if (addr == hcbd_pkg::ADDR_KEYS_B) begin
            v = {r7[3:0], r0[7], r0[6], 2'b00};
          end else if (addr == hcbd_pkg::ADDR_CASS_JOY) begin
            v = stick_bits(j2);
          end else begin
            v = OPEN_BUS;
          end
          beats.push_back(make_beat(hcbd_pkg::KIND_DATA, v, hcbd_pkg::ROM_IPL, 15'd0,
                                    1'b0, 1'b0));
        end
      end
      hcbd_pkg::OP_MEM_WRITE: begin
        // writes below the i/o page fall through with no beat
        if (addr < hcbd_pkg::ADDR_IO_BASE) begin
        end else if (addr == hcbd_pkg::ADDR_VDP_DATA || addr == hcbd_pkg::ADDR_VDP_CTRL) begin
          beats.push_back(make_beat(hcbd_pkg::KIND_VDP_WRITE, data, hcbd_pkg::ROM_IPL, 15'd0,
                                    addr == hcbd_pkg::ADDR_VDP_CTRL, 1'b0));
        end else if (addr == hcbd_pkg::ADDR_CART_OFF && basic_present) begin
          cart_on = 1'b0;
        end else if (addr == hcbd_pkg::ADDR_CART_ON && basic_present) begin
          cart_on = 1'b1;
        end else if (addr == hcbd_pkg::ADDR_PSG) begin
          beats.push_back(make_beat(hcbd_pkg::KIND_PSG_WRITE, data, hcbd_pkg::ROM_IPL, 15'd0,
                                    1'b0, 1'b0));
        end else if (addr[15:8] == hcbd_pkg::CASS_PAGE && addr[4:0] == 5'd0) begin
          if (addr[7:6] == hcbd_pkg::CASS_SUB_OUT) begin
            if (addr[5] != cass_level) begin
              beats.push_back(make_beat(hcbd_pkg::KIND_CASS_OUT, 8'h00, hcbd_pkg::ROM_IPL,
                                        15'd0, 1'b0, addr[5]));
              cass_level = addr[5];
            end
          end else if (addr[7:6] == hcbd_pkg::CASS_SUB_REMOTE) begin
            want_remote = (data == 8'h00);
            if (want_remote != remote_on) begin
              if (!want_remote)
                beats.push_back(make_beat(hcbd_pkg::KIND_INT4, 8'h00, hcbd_pkg::ROM_IPL,
                                          15'd0, 1'b0, 1'b0));
              beats.push_back(make_beat(hcbd_pkg::KIND_REMOTE, 8'h00, hcbd_pkg::ROM_IPL,
                                        15'd0, 1'b0, want_remote));
              remote_on = want_remote;
            end
          end
        end
      end
      hcbd_pkg::OP_CRU_READ: begin
        if (cru[11:3] == hcbd_pkg::CRU_KEY_BASE) begin
          v = matrix_row(keys, cru[2:0]);
          if (cru[2:0] == 3'd4)
            v = v | stick_bits(j1);
          else if (cru[2:0] == 3'd5)
            v = v | stick_bits(j2);
        end else if (cru == hcbd_pkg::CRU_CASS_IN) begin
          v = {7'd0, cass_level};
        end else begin
          v = OPEN_BUS;
        end
        beats.push_back(make_beat(hcbd_pkg::KIND_DATA, v, hcbd_pkg::ROM_IPL, 15'd0,
                                  1'b0, 1'b0));
      end
      default: begin
        if (lvl != cass_level) begin
          if (remote_on)
            beats.push_back(make_beat(hcbd_pkg::KIND_INT4, 8'h00, hcbd_pkg::ROM_IPL, 15'd0,
                                      1'b0, lvl));
          cass_level = lvl;
        end
      end
    endcase
    if (beats.size() > 0)
      beats[beats.size() - 1].last = 1'b1;
    foreach (beats[k])
      decoded_results.push_back(beats[k]);
  endtask

  task automatic check_field(string name, logic [14:0] want, logic [14:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  task automatic compare_result();
    hcbd_pkg::res_t want;
    seen++;
    if (decoded_results.size() == 0) begin
      $error("result beat with nothing expected: kind %0d value %0h",
             result_kind_i, read_value_i);
      fails++;
    end else begin
      want = decoded_results.pop_front();
      check_field("result_kind", 15'(want.kind), 15'(result_kind_i));
      check_field("read_value", 15'(want.value), 15'(read_value_i));
      check_field("rom_select", 15'(want.rom_sel), 15'(rom_select_i));
      check_field("rom_offset", want.rom_off, rom_offset_i);
      check_field("vdp_port", 15'(want.vdp_port), 15'(vdp_port_i));
      check_field("signal_level", 15'(want.level), 15'(signal_level_i));
      check_field("last_result", 15'(want.last), 15'(last_result_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basic_present = 1'b0;
      cart_size     = hcbd_pkg::CART_TYPE_NONE;
      cart_on       = 1'b0;
      cass_level    = 1'b0;
      remote_on     = 1'b0;
      decoded_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          hcbd_pkg::CFG_HAS_BASIC_ROM: basic_present = cfg_data_i[0];
          hcbd_pkg::CFG_CART_TYPE: begin
            cart_size = cfg_data_i;
            cart_on   = (cfg_data_i != hcbd_pkg::CART_TYPE_NONE);
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        decode_bus_event(hcbd_pkg::op_e'(operation_i), address_i, write_data_i,
                         cassette_level_i, key_rows_i, joy_one_i, joy_two_i);
      if (out_valid_i && out_ready_i)
        compare_result();
    end
  end

endmodule

// ===== tb/sv/tb_home_computer_bus_decoder.sv =====
`timescale 1ns / 1ps

module tb_home_computer_bus_decoder;

  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_EVENTS   = 240;
  localparam int unsigned LONG_HOLD      = 64;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RUN_LIMIT_NS   = 3_000_000;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // config write channel
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [hcbd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = hcbd_pkg::CFG_HAS_BASIC_ROM;
  logic [hcbd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i  = '0;

  // bus event channel
  logic                          in_valid_i       = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    operation_i      = hcbd_pkg::OP_MEM_READ;
  logic [15:0]                   address_i        = '0;
  logic [7:0]                    write_data_i     = '0;
  logic                          cassette_level_i = 1'b0;
  logic [hcbd_pkg::KEY_BITS-1:0] key_rows_i       = '0;
  logic [hcbd_pkg::JOY_BITS-1:0] joy_one_i        = '0;
  logic [hcbd_pkg::JOY_BITS-1:0] joy_two_i        = '0;

  // result channel
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [7:0]  read_value_o;
  logic [1:0]  rom_select_o;
  logic [14:0] rom_offset_o;
  logic        vdp_port_o;
  logic        signal_level_o;
  logic        last_result_o;

  // separate idle mixes for the sender and the receiver
  int unsigned sender_idle_pct   = 12;
  int unsigned receiver_idle_pct = 73;
  bit          hold_request      = 1'b0;
  int unsigned events_sent       = 0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;

  always #5 clk_i = ~clk_i;

  home_computer_bus_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .cassette_level_i(cassette_level_i),
    .key_rows_i      (key_rows_i),
    .joy_one_i       (joy_one_i),
    .joy_two_i       (joy_two_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .read_value_o    (read_value_o),
    .rom_select_o    (rom_select_o),
    .rom_offset_o    (rom_offset_o),
    .vdp_port_o      (vdp_port_o),
    .signal_level_o  (signal_level_o),
    .last_result_o   (last_result_o)
  );

  // watches all three channels, predicts and compares
  bus_decode_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .operation_i     (operation_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .cassette_level_i(cassette_level_i),
    .key_rows_i      (key_rows_i),
    .joy_one_i       (joy_one_i),
    .joy_two_i       (joy_two_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_i   (result_kind_o),
    .read_value_i    (read_value_o),
    .rom_select_i    (rom_select_o),
    .rom_offset_i    (rom_offset_o),
    .vdp_port_i      (vdp_port_o),
    .signal_level_i  (signal_level_o),
    .last_result_i   (last_result_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_seen_o  (results_seen)
  );

  // receiver: random back-pressure, plus a long hold on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // one bus event beat; called at a falling edge, returns at a falling edge
  // valid is only lowered inside a gap so it never drops and rises in one step
  task automatic send_event(hcbd_pkg::op_e op, logic [15:0] addr, logic [7:0] data,
                            logic lvl, logic [63:0] keys, logic [5:0] j1, logic [5:0] j2);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    address_i        <= addr;
    write_data_i     <= data;
    cassette_level_i <= lvl;
    key_rows_i       <= keys;
    joy_one_i        <= j1;
    joy_two_i        <= j2;
    @(posedge clk_i);
    while (!in_ready_o)
      @(posedge clk_i);
    events_sent++;
    @(negedge clk_i);
  endtask

  // directed beats use every key and stick bit set to expose the matrix mask
  task automatic send_fixed(hcbd_pkg::op_e op, logic [15:0] addr, logic [7:0] data,
                            logic lvl);
    send_event(op, addr, data, lvl, '1, '1, '1);
  endtask

  // register write, valid left high for a following write
  task automatic write_reg(logic [hcbd_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [hcbd_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(logic basic, logic [1:0] cart);
    write_reg(hcbd_pkg::CFG_HAS_BASIC_ROM, {1'b0, basic});
    write_reg(hcbd_pkg::CFG_CART_TYPE, cart);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering, wait out every expected beat and let zero-result events settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // addresses biased toward decode boundaries and the i/o registers
  function automatic logic [15:0] pick_address(hcbd_pkg::op_e op);
    int unsigned pick;
    pick = $urandom_range(99);
    if (op == hcbd_pkg::OP_CRU_READ) begin
      if (pick < 50)
        return {4'($urandom), hcbd_pkg::CRU_KEY_BASE, 3'($urandom)};
      if (pick < 65)
        return {4'($urandom), hcbd_pkg::CRU_CASS_IN};
      return 16'($urandom);
    end
    if (op == hcbd_pkg::OP_MEM_WRITE && pick < 10)
      return ($urandom_range(1) == 1) ? hcbd_pkg::ADDR_CART_ON : hcbd_pkg::ADDR_CART_OFF;
    if (pick < 30)
      return 16'($urandom);
    if (pick < 45)
      return {4'hE, 12'($urandom)};
    if (pick < 65)
      return {hcbd_pkg::CASS_PAGE, 2'($urandom), 1'($urandom), 5'd0};
    case ($urandom_range(19))
      0:       return hcbd_pkg::ADDR_VDP_DATA;
      1:       return hcbd_pkg::ADDR_VDP_CTRL;
      2:       return hcbd_pkg::ADDR_CART_OFF;
      3:       return hcbd_pkg::ADDR_CART_ON;
      4:       return hcbd_pkg::ADDR_ZERO_A;
      5:       return hcbd_pkg::ADDR_PSG;
      6:       return hcbd_pkg::ADDR_JOY_ONE;
      7:       return hcbd_pkg::ADDR_ZERO_B;
      8:       return hcbd_pkg::ADDR_KEYS_A;
      9:       return hcbd_pkg::ADDR_KEYS_B;
      10:      return hcbd_pkg::ADDR_CASS_JOY;
      11:      return hcbd_pkg::ADDR_LOW_BANK - 16'd1;
      12:      return hcbd_pkg::ADDR_LOW_BANK;
      13:      return hcbd_pkg::ADDR_HIGH_BANK - 16'd1;
      14:      return hcbd_pkg::ADDR_HIGH_BANK;
      15:      return hcbd_pkg::ADDR_ROM_END - 16'd1;
      16:      return hcbd_pkg::ADDR_ROM_END;
      17:      return hcbd_pkg::ADDR_IO_BASE - 16'd1;
      18:      return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic random_event();
    int unsigned   pick;
    hcbd_pkg::op_e op;
    logic [7:0]    data;
    pick = $urandom_range(99);
    if (pick < 35)
      op = hcbd_pkg::OP_MEM_READ;
    else if (pick < 70)
      op = hcbd_pkg::OP_MEM_WRITE;
    else if (pick < 85)
      op = hcbd_pkg::OP_CRU_READ;
    else
      op = hcbd_pkg::OP_CASS_IN;
    // zero data half the time so remote writes switch both ways
    data = ($urandom_range(1) == 1) ? 8'h00 : 8'($urandom);
    send_event(op, pick_address(op), data, 1'($urandom), {$urandom, $urandom},
               6'($urandom), 6'($urandom));
  endtask

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic        basic;
    logic [1:0]  cart;
    reset_done: begin
      rst_ni = 1'b0;
      repeat (2) @(posedge clk_i);
      @(negedge clk_i);
      rst_ni = 1'b1;
    end

    // directed beats at reset config: cartridge unmapped, no basic rom
    send_fixed(hcbd_pkg::OP_MEM_READ, 16'h0000, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_HIGH_BANK - 16'd1, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_HIGH_BANK, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_ROM_END - 16'd1, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_ROM_END, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_VDP_DATA, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_VDP_CTRL, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_WRITE, hcbd_pkg::ADDR_VDP_DATA, 8'hFF, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_WRITE, hcbd_pkg::ADDR_VDP_CTRL, 8'h00, 1'b0);
    // write below the i/o page is dropped
    send_fixed(hcbd_pkg::OP_MEM_WRITE, 16'h1234, 8'h5A, 1'b1);
    send_fixed(hcbd_pkg::OP_MEM_WRITE, hcbd_pkg::ADDR_PSG, 8'hA5, 1'b0);
    // the two i/o reads that return zero
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_ZERO_A, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_ZERO_B, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_JOY_ONE, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_KEYS_A, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_KEYS_B, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_MEM_READ, hcbd_pkg::ADDR_CASS_JOY, 8'h00, 1'b0);
    // unused i/o read
    send_fixed(hcbd_pkg::OP_MEM_READ, 16'hFFFF, 8'h00, 1'b0);
    // cru key rows with stick bits merged, upper address bits ignored
    send_fixed(hcbd_pkg::OP_CRU_READ, {4'hF, hcbd_pkg::CRU_KEY_BASE, 3'd5}, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_CRU_READ, {4'h0, hcbd_pkg::CRU_KEY_BASE, 3'd4}, 8'h00, 1'b0);
    // cassette out high, then read back over cru
    send_fixed(hcbd_pkg::OP_MEM_WRITE,
               {hcbd_pkg::CASS_PAGE, hcbd_pkg::CASS_SUB_OUT, 1'b1, 5'd0}, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_CRU_READ, {4'h0, hcbd_pkg::CRU_CASS_IN}, 8'h00, 1'b0);
    // remote on, cassette input change drives int4 low, repeat level does nothing
    send_fixed(hcbd_pkg::OP_MEM_WRITE,
               {hcbd_pkg::CASS_PAGE, hcbd_pkg::CASS_SUB_REMOTE, 1'b0, 5'd0}, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_CASS_IN, 16'h0000, 8'h00, 1'b0);
    send_fixed(hcbd_pkg::OP_CASS_IN, 16'h0000, 8'h00, 1'b0);
    // remote off gives int4 low then remote, two beats
    send_fixed(hcbd_pkg::OP_MEM_WRITE,
               {hcbd_pkg::CASS_PAGE, hcbd_pkg::CASS_SUB_REMOTE, 1'b0, 5'd0}, 8'h01, 1'b0);
    drain_results();

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: begin basic = 1'b1; cart = hcbd_pkg::CART_TYPE_32K;  end
        1: begin basic = 1'b0; cart = 2'd1;                     end
        2: begin basic = 1'b1; cart = 2'd2;                     end
        3: begin basic = 1'b0; cart = hcbd_pkg::CART_TYPE_NONE; end
        4: begin basic = 1'b1; cart = hcbd_pkg::CART_TYPE_NONE; end
        default: begin basic = 1'b0; cart = hcbd_pkg::CART_TYPE_32K; end
      endcase
      // sender mostly busy first, then receiver mostly busy, then no idling
      if (p < 2) begin
        sender_idle_pct   = 12;
        receiver_idle_pct = 73;
      end else if (p < 4) begin
        sender_idle_pct   = 73;
        receiver_idle_pct = 12;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      apply_setting(basic, cart);
      for (int unsigned i = 0; i < PHASE_EVENTS; i++) begin
        // long receiver hold while beats keep coming, fills the result fifo
        if (p == 4 && i == 40)
          hold_request = 1'b1;
        // sender pause until the block has emptied
        if (p == 2 && i == 120)
          drain_results();
        random_event();
      end
      drain_results();
    end

    $display("summary: %0d bus events over %0d register settings, %0d result beats compared",
             events_sent, PHASES + 1, results_seen);
    $display("summary: both idle mixes, a long receiver hold and mid-phase drains exercised");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
